>>> sv/cnp_pkg.sv
package cnp_pkg;

   localparam int CP_W    = 21;
   localparam int VALUE_W = 63;
   localparam int DIGIT_W = 4;
   localparam int TERM_W  = 14;   // largest unit term is 9 * 1000
   localparam int SCALE_W = 27;   // holds 10^8
   localparam int PP_LO_W = 25;   // multiplicand split, low part
   localparam int PP_HI_W = 25;   // multiplicand split, high part
   localparam int PP_W    = PP_LO_W + SCALE_W;

   localparam logic [VALUE_W-1:0] VMAX      = {VALUE_W{1'b1}};
   localparam logic [SCALE_W-1:0] WAN_SCALE = SCALE_W'(10000);
   localparam logic [SCALE_W-1:0] YI_SCALE  = SCALE_W'(100000000);
   localparam logic [VALUE_W-1:0] WAN_LIMIT = VMAX / VALUE_W'(10000);
   localparam logic [VALUE_W-1:0] YI_LIMIT  = VMAX / VALUE_W'(100000000);

   // character codes
   localparam logic [CP_W-1:0] CP_ZERO     = CP_W'(32'h96F6);
   localparam logic [CP_W-1:0] CP_ONE      = CP_W'(32'h4E00);
   localparam logic [CP_W-1:0] CP_TWO      = CP_W'(32'h4E8C);
   localparam logic [CP_W-1:0] CP_TWO_ALT  = CP_W'(32'h4E24);
   localparam logic [CP_W-1:0] CP_THREE    = CP_W'(32'h4E09);
   localparam logic [CP_W-1:0] CP_FOUR     = CP_W'(32'h56DB);
   localparam logic [CP_W-1:0] CP_FIVE     = CP_W'(32'h4E94);
   localparam logic [CP_W-1:0] CP_SIX      = CP_W'(32'h516D);
   localparam logic [CP_W-1:0] CP_SEVEN    = CP_W'(32'h4E03);
   localparam logic [CP_W-1:0] CP_EIGHT    = CP_W'(32'h516B);
   localparam logic [CP_W-1:0] CP_NINE     = CP_W'(32'h4E5D);
   localparam logic [CP_W-1:0] CP_TEN      = CP_W'(32'h5341);
   localparam logic [CP_W-1:0] CP_HUNDRED  = CP_W'(32'h767E);
   localparam logic [CP_W-1:0] CP_THOUSAND = CP_W'(32'h5343);
   localparam logic [CP_W-1:0] CP_WAN      = CP_W'(32'h4E07);
   localparam logic [CP_W-1:0] CP_YI       = CP_W'(32'h4EBF);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DIGIT,
      OP_UNIT,
      OP_WAN,
      OP_YI
   } op_kind_type;

   typedef enum logic [1:0] {
      UNIT_TEN,
      UNIT_HUNDRED,
      UNIT_THOUSAND
   } unit_sel_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [DIGIT_W-1:0]   digit;
      unit_sel_type         unit;
      logic                 last;
   } op_type;

   typedef enum logic [1:0] {
      STEP_OP,
      STEP_MUL_A,
      STEP_MUL_B,
      STEP_FIN
   } step_type;

endpackage

>>> sv/cnp_front.sv
module cnp_front
   import cnp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [CP_W-1:0] req_code_point,
   input  logic            req_tlast,
   output logic            push_valid,
   input  logic            push_ready,
   output op_type          push_data
);

   // set once a beat of the current numeral has been taken; cleared by the last beat
   logic started_ff;
   logic started_in;

   always_comb begin
      started_in = started_ff;
      if (req_tvalid && push_ready) begin
         started_in = !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_data       = '0;
      push_data.kind  = OP_NONE;
      push_data.unit  = UNIT_TEN;
      push_data.last  = req_tlast;
      push_data.digit = '0;
      case (req_code_point)
         CP_ZERO:     begin push_data.kind = OP_DIGIT; push_data.digit = 4'd0; end
         CP_ONE:      begin push_data.kind = OP_DIGIT; push_data.digit = 4'd1; end
         CP_TWO:      begin push_data.kind = OP_DIGIT; push_data.digit = 4'd2; end
         CP_TWO_ALT:  begin push_data.kind = OP_DIGIT; push_data.digit = 4'd2; end
         CP_THREE:    begin push_data.kind = OP_DIGIT; push_data.digit = 4'd3; end
         CP_FOUR:     begin push_data.kind = OP_DIGIT; push_data.digit = 4'd4; end
         CP_FIVE:     begin push_data.kind = OP_DIGIT; push_data.digit = 4'd5; end
         CP_SIX:      begin push_data.kind = OP_DIGIT; push_data.digit = 4'd6; end
         CP_SEVEN:    begin push_data.kind = OP_DIGIT; push_data.digit = 4'd7; end
         CP_EIGHT:    begin push_data.kind = OP_DIGIT; push_data.digit = 4'd8; end
         CP_NINE:     begin push_data.kind = OP_DIGIT; push_data.digit = 4'd9; end
         CP_TEN:      begin push_data.kind = OP_UNIT;  push_data.unit = UNIT_TEN; end
         CP_HUNDRED:  begin push_data.kind = OP_UNIT;  push_data.unit = UNIT_HUNDRED; end
         CP_THOUSAND: begin push_data.kind = OP_UNIT;  push_data.unit = UNIT_THOUSAND; end
         CP_WAN:      push_data.kind = OP_WAN;
         CP_YI:       push_data.kind = OP_YI;
         default: begin
            // unknown characters travel as no-ops so that last still counts;
            // a lone unknown first beat carries no state either way
            push_data.kind = started_ff ? OP_NONE : OP_NONE;
         end
      endcase
   end

endmodule

>>> sv/cnp_queue.sv
module cnp_queue
   import cnp_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_data,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/cnp_back.sv
module cnp_back
   import cnp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               op_valid,
   output logic               op_ready,
   input  op_type             op_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_overflow
);

   step_type            state_ff;
   step_type            state_in;
   logic [VALUE_W-1:0]  total_ff;
   logic [VALUE_W-1:0]  total_in;
   logic [VALUE_W-1:0]  seg_ff;
   logic [VALUE_W-1:0]  seg_in;
   logic [DIGIT_W-1:0]  pend_ff;
   logic [DIGIT_W-1:0]  pend_in;
   logic                pend_vld_ff;
   logic                pend_vld_in;
   logic                ovf_ff;
   logic                ovf_in;
   logic                is_yi_ff;
   logic                is_yi_in;
   logic                last_ff;
   logic                last_in;
   logic [PP_W-1:0]     pp_lo_ff;
   logic [PP_W-1:0]     pp_lo_in;
   logic [PP_W-1:0]     pp_hi_ff;
   logic [PP_W-1:0]     pp_hi_in;
   logic                mul_ovf_ff;
   logic                mul_ovf_in;
   logic                rsp_vld_ff;
   logic                rsp_vld_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [VALUE_W-1:0]  rsp_value_in;
   logic                rsp_ovf_ff;
   logic                rsp_ovf_in;

   logic                pop;
   logic                out_free;
   logic [VALUE_W-1:0]  pend_val;
   logic [VALUE_W-1:0]  mul_operand;
   logic [VALUE_W-1:0]  mul_limit;
   logic [SCALE_W-1:0]  mul_scale;
   logic [VALUE_W+1:0]  sum_r;
   logic [VALUE_W-1:0]  sum_a;
   logic [VALUE_W-1:0]  sum_b;
   logic [VALUE_W-1:0]  sum_c;
   logic [VALUE_W-1:0]  sum_val;
   logic                sum_ovf;
   logic [VALUE_W-1:0]  pp_hi_sh;

   // digit (or 1) times ten, hundred or thousand
   function automatic logic [TERM_W-1:0] unit_term(input logic [DIGIT_W-1:0] d,
                                                   input unit_sel_type u);
      logic [TERM_W-1:0] t;
      case (u)
         UNIT_TEN:      t = TERM_W'(d) * TERM_W'(10);
         UNIT_HUNDRED:  t = TERM_W'(d) * TERM_W'(100);
         UNIT_THOUSAND: t = TERM_W'(d) * TERM_W'(1000);
         default:       t = '0;
      endcase
      return t;
   endfunction

   assign out_free = !rsp_vld_ff || rsp_tready;
   assign op_ready = (state_ff == STEP_OP);
   assign pop      = op_valid && op_ready;
   assign pend_val = pend_vld_ff ? VALUE_W'(pend_ff) : '0;
   assign pp_hi_sh = VALUE_W'({pp_hi_ff, {PP_LO_W{1'b0}}});

   // shared three-input saturating adder; all operands stay at or below VMAX,
   // two carry bits cover the full sum
   assign sum_r   = (VALUE_W+2)'(sum_a) + (VALUE_W+2)'(sum_b) + (VALUE_W+2)'(sum_c);
   assign sum_ovf = |sum_r[VALUE_W+1:VALUE_W];
   assign sum_val = sum_ovf ? VMAX : sum_r[VALUE_W-1:0];

   // multiplier operand select
   always_comb begin
      if (is_yi_ff) begin
         mul_operand = total_ff;
         mul_scale   = YI_SCALE;
         mul_limit   = YI_LIMIT;
      end else begin
         mul_operand = (seg_ff == '0) ? VALUE_W'(1) : seg_ff;
         mul_scale   = WAN_SCALE;
         mul_limit   = WAN_LIMIT;
      end
   end

   // next step
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STEP_OP: begin
            if (pop) begin
               if (op_data.kind == OP_WAN || op_data.kind == OP_YI) begin
                  state_in = STEP_MUL_A;
               end else if (op_data.last) begin
                  state_in = STEP_FIN;
               end
            end
         end
         STEP_MUL_A: state_in = STEP_MUL_B;
         STEP_MUL_B: state_in = last_ff ? STEP_FIN : STEP_OP;
         STEP_FIN: begin
            if (out_free) begin
               state_in = STEP_OP;
            end
         end
         default: state_in = STEP_OP;
      endcase
   end

   // datapath
   always_comb begin
      total_in     = total_ff;
      seg_in       = seg_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      ovf_in       = ovf_ff;
      is_yi_in     = is_yi_ff;
      last_in      = last_ff;
      pp_lo_in     = pp_lo_ff;
      pp_hi_in     = pp_hi_ff;
      mul_ovf_in   = mul_ovf_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      sum_a        = seg_ff;
      sum_b        = pend_val;
      sum_c        = '0;
      case (state_ff)
         STEP_OP: begin
            if (pop) begin
               last_in = op_data.last;
               case (op_data.kind)
                  OP_DIGIT: begin
                     seg_in      = sum_val;
                     ovf_in      = ovf_ff | sum_ovf;
                     pend_in     = op_data.digit;
                     pend_vld_in = 1'b1;
                  end
                  OP_UNIT: begin
                     sum_b       = VALUE_W'(unit_term(pend_vld_ff ? pend_ff : DIGIT_W'(1),
                                                      op_data.unit));
                     seg_in      = sum_val;
                     ovf_in      = ovf_ff | sum_ovf;
                     pend_in     = '0;
                     pend_vld_in = 1'b0;
                  end
                  OP_WAN: begin
                     seg_in      = sum_val;
                     ovf_in      = ovf_ff | sum_ovf;
                     pend_in     = '0;
                     pend_vld_in = 1'b0;
                     is_yi_in    = 1'b0;
                  end
                  OP_YI: begin
                     sum_c       = total_ff;
                     total_in    = sum_val;
                     seg_in      = '0;
                     ovf_in      = ovf_ff | sum_ovf;
                     pend_in     = '0;
                     pend_vld_in = 1'b0;
                     is_yi_in    = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         STEP_MUL_A: begin
            mul_ovf_in = (mul_operand > mul_limit);
            pp_lo_in   = PP_W'(mul_operand[PP_LO_W-1:0]) * PP_W'(mul_scale);
            pp_hi_in   = PP_W'(mul_operand[PP_LO_W+PP_HI_W-1:PP_LO_W]) * PP_W'(mul_scale);
         end
         STEP_MUL_B: begin
            sum_a    = is_yi_ff ? '0 : total_ff;
            sum_b    = VALUE_W'(pp_lo_ff);
            sum_c    = pp_hi_sh;
            total_in = mul_ovf_ff ? VMAX : sum_val;
            ovf_in   = ovf_ff | mul_ovf_ff | sum_ovf;
            seg_in   = '0;
         end
         STEP_FIN: begin
            sum_c = total_ff;
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_value_in = sum_val;
               rsp_ovf_in   = ovf_ff | sum_ovf;
               total_in     = '0;
               seg_in       = '0;
               pend_in      = '0;
               pend_vld_in  = 1'b0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= STEP_OP;
         total_ff    <= '0;
         seg_ff      <= '0;
         pend_ff     <= '0;
         pend_vld_ff <= 1'b0;
         ovf_ff      <= 1'b0;
         is_yi_ff    <= 1'b0;
         last_ff     <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         seg_ff      <= seg_in;
         pend_ff     <= pend_in;
         pend_vld_ff <= pend_vld_in;
         ovf_ff      <= ovf_in;
         is_yi_ff    <= is_yi_in;
         last_ff     <= last_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pp_lo_ff     <= pp_lo_in;
      pp_hi_ff     <= pp_hi_in;
      mul_ovf_ff   <= mul_ovf_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

>>> sv/chinese_numeral_parser.sv
// Channel   Dir  Beat fields (low bit first)              Handshake
// req_      in   tdata: code_point[20:0], zero pad         tvalid/tready, tlast = last
// rsp_      out  tdata: value[62:0], zero pad              tvalid/tready, tuser = overflow
//
// A front decoder classifies each character and pushes it into a short queue;
// the back end executes one queued op at a time against the running total.
// Digits, ten/hundred/thousand and ignored characters need only the back end's
// op step; wan and yi also take the steps flush, split constant multiply, combine.
// A tlast beat adds a final step to fold everything and load the result register.
// Reset is synchronous; req_tready drops only when the queue is full, and a
// stalled result holds in the output register while the queue keeps filling.
module chinese_numeral_parser
   import cnp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // code_point[20:0], pad[23:21]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // value[62:0], pad[63]
   output logic        rsp_tuser     // overflow
);

   logic               push_valid;
   logic               push_ready;
   op_type             push_data;
   logic               op_valid;
   logic               op_ready;
   op_type             op_data;
   logic [VALUE_W-1:0] rsp_value;

   cnp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_code_point (req_tdata[CP_W-1:0]),
      .req_tlast      (req_tlast),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   cnp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (op_valid),
      .pop_ready  (op_ready),
      .pop_data   (op_data)
   );

   cnp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .op_valid     (op_valid),
      .op_ready     (op_ready),
      .op_data      (op_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, rsp_value};

endmodule

>>> tb/chinese_numeral_parser_tb.sv
module chinese_numeral_parser_tb;
   import cnp_pkg::*;

   localparam int QUIET_TAIL   = 200;   // last beats of the run go without idling
   localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX   = 10;
   localparam int TARGET_CHARS = 1800;

   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            last;
   } char_beat_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               overflow;
   } number_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // code_point[20:0], pad[23:21]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // value[62:0], pad[63]
   logic        rsp_tuser;        // overflow

   char_beat_type char_queue[$];
   number_type    expected_numbers[$];
   int            mismatch_count = 0;
   int            gap_left = 0;
   int            stall_left = 0;
   int            idle_cycles = 0;
   int            counted_chars = 0;

   // running parse state
   logic [VALUE_W-1:0] run_total;
   logic [VALUE_W-1:0] run_segment;
   logic [DIGIT_W-1:0] held_digit;
   logic               digit_held;
   logic               saturated;

   logic [CP_W-1:0] digit_cps[11] = '{CP_ZERO, CP_ONE, CP_TWO, CP_TWO_ALT, CP_THREE, CP_FOUR,
                                      CP_FIVE, CP_SIX, CP_SEVEN, CP_EIGHT, CP_NINE};
   logic [CP_W-1:0] unit_cps[5]  = '{CP_TEN, CP_HUNDRED, CP_THOUSAND, CP_WAN, CP_YI};

   always #1 clock = ~clock;

   chinese_numeral_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // --------------------------------------------------------------------
   // Parse predictor
   // --------------------------------------------------------------------

   function automatic op_type decode_char(logic [CP_W-1:0] cp);
      op_type op;
      op = '{kind: OP_NONE, digit: '0, unit: UNIT_TEN, last: 1'b0};
      case (cp)
         CP_ZERO:     begin op.kind = OP_DIGIT; op.digit = 4'd0; end
         CP_ONE:      begin op.kind = OP_DIGIT; op.digit = 4'd1; end
         CP_TWO,
         CP_TWO_ALT:  begin op.kind = OP_DIGIT; op.digit = 4'd2; end
         CP_THREE:    begin op.kind = OP_DIGIT; op.digit = 4'd3; end
         CP_FOUR:     begin op.kind = OP_DIGIT; op.digit = 4'd4; end
         CP_FIVE:     begin op.kind = OP_DIGIT; op.digit = 4'd5; end
         CP_SIX:      begin op.kind = OP_DIGIT; op.digit = 4'd6; end
         CP_SEVEN:    begin op.kind = OP_DIGIT; op.digit = 4'd7; end
         CP_EIGHT:    begin op.kind = OP_DIGIT; op.digit = 4'd8; end
         CP_NINE:     begin op.kind = OP_DIGIT; op.digit = 4'd9; end
         CP_TEN:      begin op.kind = OP_UNIT; op.unit = UNIT_TEN; end
         CP_HUNDRED:  begin op.kind = OP_UNIT; op.unit = UNIT_HUNDRED; end
         CP_THOUSAND: begin op.kind = OP_UNIT; op.unit = UNIT_THOUSAND; end
         CP_WAN:      op.kind = OP_WAN;
         CP_YI:       op.kind = OP_YI;
         default:     op.kind = OP_NONE;
      endcase
      return op;
   endfunction

   // sum above 2^63-1 clamps and marks the numeral as overflowed
   function automatic logic [VALUE_W-1:0] add_clamped(logic [VALUE_W-1:0] a,
                                                      logic [VALUE_W-1:0] b);
      logic [VALUE_W:0] sum;
      sum = a + b;
      if (sum[VALUE_W]) begin
         saturated = 1'b1;
         return VMAX;
      end
      return sum[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] mul_clamped(logic [VALUE_W-1:0] a,
                                                      logic [SCALE_W-1:0] k);
      logic [VALUE_W+SCALE_W-1:0] prod;
      prod = a * k;
      if (|prod[VALUE_W+SCALE_W-1:VALUE_W]) begin
         saturated = 1'b1;
         return VMAX;
      end
      return prod[VALUE_W-1:0];
   endfunction

   function automatic void clear_parse();
      run_total   = '0;
      run_segment = '0;
      held_digit  = '0;
      digit_held  = 1'b0;
      saturated   = 1'b0;
   endfunction

   function automatic void fold_digit();
      if (digit_held)
         run_segment = add_clamped(run_segment, VALUE_W'(held_digit));
      digit_held = 1'b0;
      held_digit = '0;
   endfunction

   // one accepted character; a closing character queues the parsed number
   function automatic void parse_char(char_beat_type beat);
      op_type             op;
      logic [SCALE_W-1:0] unit_val;
      logic [VALUE_W-1:0] mult;
      number_type         num;
      op = decode_char(beat.cp);
      case (op.kind)
         OP_DIGIT: begin
            if (digit_held)
               run_segment = add_clamped(run_segment, VALUE_W'(held_digit));
            held_digit = op.digit;
            digit_held = 1'b1;
         end
         OP_UNIT: begin
            case (op.unit)
               UNIT_TEN:     unit_val = SCALE_W'(10);
               UNIT_HUNDRED: unit_val = SCALE_W'(100);
               default:      unit_val = SCALE_W'(1000);
            endcase
            // bare unit counts as one of it
            mult = digit_held ? VALUE_W'(held_digit) : VALUE_W'(1);
            run_segment = add_clamped(run_segment, mul_clamped(mult, unit_val));
            digit_held = 1'b0;
            held_digit = '0;
         end
         OP_WAN: begin
            fold_digit();
            // empty segment before wan means one wan
            mult = (run_segment != '0) ? run_segment : VALUE_W'(1);
            run_total = add_clamped(run_total, mul_clamped(mult, WAN_SCALE));
            run_segment = '0;
         end
         OP_YI: begin
            fold_digit();
            run_total = add_clamped(run_total, run_segment);
            run_total = mul_clamped(run_total, YI_SCALE);
            run_segment = '0;
         end
         default: ;   // unknown character, state untouched
      endcase
      if (beat.last) begin
         fold_digit();
         run_total = add_clamped(run_total, run_segment);
         num.value    = run_total;
         num.overflow = saturated;
         expected_numbers.push_back(num);
         clear_parse();
      end
   endfunction

   // --------------------------------------------------------------------
   // Stimulus builders
   // --------------------------------------------------------------------

   function automatic void add_char(logic [CP_W-1:0] cp, logic last = 1'b0);
      char_beat_type beat;
      beat.cp   = cp;
      beat.last = last;
      char_queue.push_back(beat);
      counted_chars++;
   endfunction

   function automatic logic [CP_W-1:0] any_digit();
      return digit_cps[$urandom_range(0, 10)];
   endfunction

   // one group below ten thousand: [d]thousand [d]hundred [zero] [d]ten [d]
   function automatic void add_segment();
      if ($urandom_range(0, 2) == 0) begin
         if ($urandom_range(0, 4) != 0) add_char(any_digit());
         add_char(CP_THOUSAND);
      end
      if ($urandom_range(0, 2) == 0) begin
         if ($urandom_range(0, 4) != 0) add_char(any_digit());
         add_char(CP_HUNDRED);
      end
      if ($urandom_range(0, 5) == 0) add_char(CP_ZERO);
      if ($urandom_range(0, 2) == 0) begin
         if ($urandom_range(0, 2) != 0) add_char(any_digit());
         add_char(CP_TEN);
      end
      if ($urandom_range(0, 1) == 0) add_char(any_digit());
      // an ignored character now and then, mid-numeral
      if ($urandom_range(0, 15) == 0) add_char(CP_W'($urandom_range(0, 1114111)));
   endfunction

   function automatic void add_numeral();
      int start;
      int groups;
      start  = char_queue.size();
      groups = $urandom_range(0, 2);
      for (int g = 0; g < groups; g++) begin
         add_segment();
         add_char(($urandom_range(0, 2) == 0) ? CP_YI : CP_WAN);
         // stacked yi drives the total toward saturation
         if ($urandom_range(0, 9) == 0) add_char(CP_YI);
      end
      add_segment();
      if (char_queue.size() == start)
         add_char(any_digit());
      char_queue[$].last = 1'b1;
   endfunction

   // broken sequences: recognized and unknown characters in any order
   function automatic void add_noise();
      int len;
      len = $urandom_range(1, 6);
      for (int n = 0; n < len; n++) begin
         case ($urandom_range(0, 2))
            0:       add_char(any_digit());
            1:       add_char(unit_cps[$urandom_range(0, 4)]);
            default: add_char(CP_W'($urandom_range(0, 1114111)));
         endcase
      end
      char_queue[$].last = 1'b1;
   endfunction

   // --------------------------------------------------------------------
   // Driver: one beat per handshake, random idle bursts until the tail
   // --------------------------------------------------------------------

   always @(posedge clock) begin
      char_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            parse_char('{cp: req_tdata[CP_W-1:0], last: req_tlast});
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (char_queue.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (char_queue.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
            // start an idle burst
            gap_left   <= $urandom_range(0, 2);
            req_tvalid <= 1'b0;
         end else begin
            beat = char_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b000, beat.cp};
            req_tlast  <= beat.last;
         end
      end
   end

   // --------------------------------------------------------------------
   // Monitor: checks each result beat against the oldest expected number
   // --------------------------------------------------------------------

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch: %s", what);
   endfunction

   always @(posedge clock) begin
      number_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_numbers.size() == 0) begin
               note_mismatch($sformatf("unexpected beat value=%0d overflow=%0b",
                                       rsp_tdata[VALUE_W-1:0], rsp_tuser));
            end else begin
               want = expected_numbers.pop_front();
               if (rsp_tdata[VALUE_W-1:0] !== want.value)
                  note_mismatch($sformatf("value expected %0d got %0d",
                                          want.value, rsp_tdata[VALUE_W-1:0]));
               if (rsp_tuser !== want.overflow)
                  note_mismatch($sformatf("overflow expected %0b got %0b",
                                          want.overflow, rsp_tuser));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (char_queue.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: no handshake on either side for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // --------------------------------------------------------------------
   // Stimulus and end of run
   // --------------------------------------------------------------------

   initial begin
      clear_parse();

      // single characters: extreme digits, bare ten; then alternate two with hundred
      add_char(CP_ZERO, 1'b1);
      add_char(CP_NINE, 1'b1);
      add_char(CP_TEN, 1'b1);
      add_char(CP_TWO_ALT);
      add_char(CP_HUNDRED, 1'b1);
      // wan with empty segment, yi with nothing before it
      add_char(CP_WAN, 1'b1);
      add_char(CP_YI, 1'b1);
      // unknown characters closing a numeral, lowest and highest code point
      add_char('0, 1'b1);
      add_char(CP_W'(1114111), 1'b1);
      // consecutive digits sum up
      add_char(CP_ONE);
      add_char(CP_TWO);
      add_char(CP_THREE, 1'b1);
      // stacked yi saturates
      add_char(CP_ONE);
      add_char(CP_YI);
      add_char(CP_YI);
      add_char(CP_YI, 1'b1);
      // full segment, remaining digits
      add_char(CP_SEVEN);
      add_char(CP_THOUSAND);
      add_char(CP_EIGHT);
      add_char(CP_HUNDRED);
      add_char(CP_SIX);
      add_char(CP_TEN);
      add_char(CP_FOUR);
      add_char(CP_FIVE, 1'b1);

      while (counted_chars < TARGET_CHARS) begin
         if ($urandom_range(0, 4) == 0) add_noise();
         else                           add_numeral();
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || req_tvalid || expected_numbers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_numbers.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
